@@ src/fpa_pkg.sv @@
// Shared types and constants for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps

package fpa_pkg;

	localparam int WORD_WIDTH    = 32;
	localparam int ACTION_WIDTH  = 4;
	localparam int FRACTION_BITS = 8;

	typedef enum logic [ACTION_WIDTH-1:0] {
		ACT_ADD      = 4'd0,
		ACT_SUB      = 4'd1,
		ACT_MUL      = 4'd2,
		ACT_DIV      = 4'd3,
		ACT_INC      = 4'd4,
		ACT_DEC      = 4'd5,
		ACT_MIN      = 4'd6,
		ACT_MAX      = 4'd7,
		ACT_FROM_INT = 4'd8
	} action_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] result;
		logic                         divide_by_zero;
		logic                         a_less;
		logic                         a_greater;
		logic                         a_equal;
	} out_t;

	typedef struct packed {
		logic [ACTION_WIDTH-1:0]      action;
		logic signed [WORD_WIDTH-1:0] simple;
		logic                         dz;
		logic                         lt;
		logic                         gt;
		logic                         eq;
	} side_t;

endpackage

@@ src/fpa_mul.sv @@
// Pipelined signed multiplier with fraction shift and latency padding.
`timescale 1ns / 1ps

module fpa_mul #(
	parameter int FracBits = fpa_pkg::FRACTION_BITS,
	parameter int Depth    = fpa_pkg::WORD_WIDTH + fpa_pkg::FRACTION_BITS + 2
) (
	input  logic                                   clk,
	input  logic                                   adv,
	input  logic signed [fpa_pkg::WORD_WIDTH-1:0]  a,
	input  logic signed [fpa_pkg::WORD_WIDTH-1:0]  b,
	output logic signed [fpa_pkg::WORD_WIDTH-1:0]  prod
);

	localparam int WW = fpa_pkg::WORD_WIDTH;

	logic signed [2*WW-1:0] prod_s1;
	logic signed [WW-1:0]   res_s [Depth-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= a * b;
			res_s[0] <= prod_s1[FracBits+WW-1:FracBits];
			for (int k = 1; k < Depth - 1; k++) begin
				res_s[k] <= res_s[k-1];
			end
		end
	end

	assign prod = res_s[Depth-2];

endmodule

@@ src/fpa_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, signed truncation.
`timescale 1ns / 1ps

module fpa_div #(
	parameter int FracBits = fpa_pkg::FRACTION_BITS
) (
	input  logic                                  clk,
	input  logic                                  adv,
	input  logic signed [fpa_pkg::WORD_WIDTH-1:0] a,
	input  logic signed [fpa_pkg::WORD_WIDTH-1:0] b,
	output logic signed [fpa_pkg::WORD_WIDTH-1:0] quo
);

	localparam int WW   = fpa_pkg::WORD_WIDTH;
	localparam int NumW = WW + FracBits;

	logic [WW-1:0]   mag_a;
	logic [WW-1:0]   mag_b;
	logic [NumW-1:0] num_s [NumW+1];
	logic [WW-1:0]   rem_s [NumW+1];
	logic [WW-1:0]   dvs_s [NumW+1];
	logic            neg_s [NumW+1];
	logic [WW:0]     part  [NumW];
	logic [WW:0]     diff  [NumW];
	logic signed [WW-1:0] quo_q;

	always_comb begin
		mag_a = a[WW-1] ? WW'(-a) : WW'(a);
		mag_b = b[WW-1] ? WW'(-b) : WW'(b);
		for (int k = 0; k < NumW; k++) begin
			part[k] = {rem_s[k], num_s[k][NumW-1]};
			diff[k] = part[k] - {1'b0, dvs_s[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s[0] <= {mag_a, {FracBits{1'b0}}};
			rem_s[0] <= '0;
			dvs_s[0] <= mag_b;
			neg_s[0] <= a[WW-1] ^ b[WW-1];
			for (int k = 0; k < NumW; k++) begin
				rem_s[k+1] <= diff[k][WW] ? part[k][WW-1:0] : diff[k][WW-1:0];
				num_s[k+1] <= {num_s[k][NumW-2:0], ~diff[k][WW]};
				dvs_s[k+1] <= dvs_s[k];
				neg_s[k+1] <= neg_s[k];
			end
			quo_q <= neg_s[NumW] ? -$signed(num_s[NumW][WW-1:0])
				: $signed(num_s[NumW][WW-1:0]);
		end
	end

	assign quo = quo_q;

endmodule

@@ src/fpa_obuf.sv @@
// Output register with one skid entry for the result channel.
`timescale 1ns / 1ps

module fpa_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fpa_pkg::out_t push_word,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output fpa_pkg::out_t out_word
);

	logic          out_valid_q;
	logic          skid_valid_q;
	fpa_pkg::out_t out_word_q;
	fpa_pkg::out_t skid_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_word_q <= skid_valid_q ? skid_word_q : push_word;
		end else if (push) begin
			skid_word_q <= push_word;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

@@ src/fixed_point_alu_unit.sv @@
// Top level of the pipelined Q24.8 fixed-point ALU.
//
//   channel | signals                                   | moves on
//   input   | action, operand_a, operand_b              | in_valid & in_ready
//   output  | result, divide_by_zero, a_less/greater/eq | out_valid & out_ready
//
// One word enters per cycle while in_ready is high; every action gives a word
// that can be taken at the output after the input, pipe and output registers.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Reset clears only the valid bits; the datapath registers are left alone.
// A stalled output holds its word and a skid entry takes one more; in_ready
// drops only when that entry is full, and the whole pipe then holds.
`timescale 1ns / 1ps

module fixed_point_alu_unit #(
	parameter int FracBits = fpa_pkg::FRACTION_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [fpa_pkg::ACTION_WIDTH-1:0]        action,
	input  logic signed [fpa_pkg::WORD_WIDTH-1:0]   operand_a,
	input  logic signed [fpa_pkg::WORD_WIDTH-1:0]   operand_b,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [fpa_pkg::WORD_WIDTH-1:0]   result,
	output logic                                    divide_by_zero,
	output logic                                    a_less,
	output logic                                    a_greater,
	output logic                                    a_equal
);

	localparam int WW        = fpa_pkg::WORD_WIDTH;
	localparam int PipeDepth = WW + FracBits + 2;
	localparam int Last      = PipeDepth - 1;

	logic                             adv;
	logic                             skid_full;
	logic                             valid_s1;
	logic [fpa_pkg::ACTION_WIDTH-1:0] action_s1;
	logic signed [WW-1:0]             a_s1;
	logic signed [WW-1:0]             b_s1;
	fpa_pkg::side_t                   side_d;
	logic                             vld_s  [PipeDepth];
	fpa_pkg::side_t                   side_s [PipeDepth];
	logic signed [WW-1:0]             mul_res;
	logic signed [WW-1:0]             div_quo;
	logic                             push;
	fpa_pkg::out_t                    push_word;
	fpa_pkg::out_t                    out_word;

	assign adv      = !skid_full;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= action;
			a_s1      <= operand_a;
			b_s1      <= operand_b;
		end
	end

	always_comb begin
		side_d.action = action_s1;
		side_d.lt     = a_s1 < b_s1;
		side_d.gt     = a_s1 > b_s1;
		side_d.eq     = a_s1 == b_s1;
		side_d.dz     = (action_s1 == fpa_pkg::ACT_DIV) && (b_s1 == '0);
		unique case (action_s1)
			fpa_pkg::ACT_ADD:      side_d.simple = a_s1 + b_s1;
			fpa_pkg::ACT_SUB:      side_d.simple = a_s1 - b_s1;
			fpa_pkg::ACT_INC:      side_d.simple = a_s1 + WW'(1);
			fpa_pkg::ACT_DEC:      side_d.simple = a_s1 - WW'(1);
			fpa_pkg::ACT_MIN:      side_d.simple = (a_s1 < b_s1) ? a_s1 : b_s1;
			fpa_pkg::ACT_MAX:      side_d.simple = (a_s1 > b_s1) ? a_s1 : b_s1;
			fpa_pkg::ACT_FROM_INT: side_d.simple = a_s1 << FracBits;
			default:               side_d.simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PipeDepth; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= valid_s1;
			for (int k = 1; k < PipeDepth; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_d;
			for (int k = 1; k < PipeDepth; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	fpa_mul #(
		.FracBits (FracBits),
		.Depth    (PipeDepth)
	) u_mul (
		.clk  (clk),
		.adv  (adv),
		.a    (a_s1),
		.b    (b_s1),
		.prod (mul_res)
	);

	fpa_div #(
		.FracBits (FracBits)
	) u_div (
		.clk (clk),
		.adv (adv),
		.a   (a_s1),
		.b   (b_s1),
		.quo (div_quo)
	);

	always_comb begin
		push                     = adv && vld_s[Last];
		push_word.divide_by_zero = side_s[Last].dz;
		push_word.a_less         = side_s[Last].lt;
		push_word.a_greater      = side_s[Last].gt;
		push_word.a_equal        = side_s[Last].eq;
		priority if (side_s[Last].action == fpa_pkg::ACT_MUL) begin
			push_word.result = mul_res;
		end else if (side_s[Last].action == fpa_pkg::ACT_DIV) begin
			push_word.result = side_s[Last].dz ? '0 : div_quo;
		end else begin
			push_word.result = side_s[Last].simple;
		end
	end

	fpa_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	assign result         = out_word.result;
	assign divide_by_zero = out_word.divide_by_zero;
	assign a_less         = out_word.a_less;
	assign a_greater      = out_word.a_greater;
	assign a_equal        = out_word.a_equal;

`ifndef SYNTH
	a_stall_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no word at the output");

	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({a_less, a_greater, a_equal}))
		else $error("comparison flags not one-hot");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result == '0)
		else $error("divide by zero with nonzero result");

	a_dz_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Last] && side_s[Last].dz |-> side_s[Last].action == fpa_pkg::ACT_DIV)
		else $error("divide-by-zero flag on a non-divide word");
`endif

endmodule
